// ----- hdl/lru_voice_allocator_defines.svh -----
// Assertion macros shared by the voice allocator checker.
`ifndef LRU_VOICE_ALLOCATOR_DEFINES_SVH
`define LRU_VOICE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, muted during reset.
`define LVA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lru_voice_allocator check failed");

// Next-cycle implication, muted during reset.
`define LVA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lru_voice_allocator check failed");

// Next-cycle implication that also covers reset cycles.
`define LVA_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lru_voice_allocator reset check failed");

`endif

// ----- hdl/lva_pkg.sv -----
// Shared constants, types and the pitch table of the voice allocator.
package lva_pkg;

  localparam int VOICES     = 16;
  localparam int NOTES      = 128;
  localparam int STAMP_BITS = 32;

  localparam int VOICE_W  = $clog2(VOICES);
  localparam int NOTE_W   = $clog2(NOTES);
  localparam int CMD_W    = 2;
  localparam int PITCH_W  = 30;
  localparam int PROD_W   = 34;
  localparam int VWORD_W  = NOTE_W + STAMP_BITS;

  // Octave split: m / 12 as (m * 43) >> 9, exact for m up to 130.
  localparam int RECIP12_MUL   = 43;
  localparam int RECIP12_SHIFT = 9;
  localparam int SEMIS         = 12;
  localparam int OCT_TOP       = 14;
  localparam int NOTE_OFFSET   = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_NOTE_ON  = 2'd0,
    CMD_NOTE_OFF = 2'd1,
    CMD_ALL_OFF  = 2'd2
  } lva_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_WRITE,
    ST_EMIT,
    ST_FLUSH
  } lva_state_t;

  // 440 Hz times round(2^(semi/12) * 2^24), one entry per semitone.
  function automatic logic [PROD_W-1:0] pitch_prod(input logic [3:0] semi);
    logic [PROD_W-1:0] p;
    case (semi)
      4'd0:    p = 34'd7381975040;
      4'd1:    p = 34'd7820930040;
      4'd2:    p = 34'd8285986720;
      4'd3:    p = 34'd8778697400;
      4'd4:    p = 34'd9300705920;
      4'd5:    p = 34'd9853754680;
      4'd6:    p = 34'd10439689040;
      4'd7:    p = 34'd11060465240;
      4'd8:    p = 34'd11718154800;
      4'd9:    p = 34'd12414952880;
      4'd10:   p = 34'd13153184000;
      4'd11:   p = 34'd13935313040;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

// ----- hdl/lva_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/lva_pitch.sv -----
// Note number to 14.16 fixed-point frequency conversion.
module lva_pitch (
  input  logic [lva_pkg::NOTE_W-1:0]  note,
  output logic [lva_pkg::PITCH_W-1:0] pitch_hz
);
  import lva_pkg::*;

  localparam int M_W   = NOTE_W + 1;
  localparam int Q_W   = M_W + 6;
  localparam int SUM_W = PROD_W + 1;

  logic [M_W-1:0]   m;
  logic [Q_W-1:0]   q;
  logic [3:0]       oct;
  logic [M_W-1:0]   oct12;
  logic [3:0]       semi;
  logic [3:0]       shamt;
  logic [SUM_W-1:0] rounded;
  logic [SUM_W-1:0] shifted;

  // Split note + 3 into octave and semitone, then scale and round half up
  always_comb begin
    m        = M_W'(note) + M_W'(NOTE_OFFSET);
    q        = Q_W'(m) * Q_W'(RECIP12_MUL);
    oct      = q[RECIP12_SHIFT +: 4];
    oct12    = M_W'(oct) * M_W'(SEMIS);
    semi     = 4'(m - oct12);
    shamt    = 4'(OCT_TOP) - oct;
    rounded  = {1'b0, pitch_prod(semi)} + (SUM_W'(1) << (shamt - 4'd1));
    shifted  = rounded >> shamt;
    pitch_hz = shifted[PITCH_W-1:0];
  end

endmodule

// ----- hdl/lva_core.sv -----
// Allocation sequencer: map lookup, age scan, write-back and result register.
module lva_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [lva_pkg::CMD_W-1:0]   in_cmd,
  input  logic [lva_pkg::NOTE_W-1:0]  in_note,
  output logic                        in_stall,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lva_pkg::VOICE_W-1:0] out_voice,
  output logic                        out_voice_on,
  output logic [lva_pkg::PITCH_W-1:0] out_pitch_hz,
  output logic                        out_last,
  output logic                        map_we,
  output logic [lva_pkg::NOTE_W-1:0]  map_waddr,
  output logic [lva_pkg::VOICE_W-1:0] map_wdata,
  output logic [lva_pkg::NOTE_W-1:0]  map_raddr,
  input  logic [lva_pkg::VOICE_W-1:0] map_rdata,
  output logic                        vce_we,
  output logic [lva_pkg::VOICE_W-1:0] vce_waddr,
  output logic [lva_pkg::VWORD_W-1:0] vce_wdata,
  output logic [lva_pkg::VOICE_W-1:0] vce_raddr,
  input  logic [lva_pkg::VWORD_W-1:0] vce_rdata
);
  import lva_pkg::*;

  lva_state_t state_r, state_nxt;

  lva_cmd_t                cmd_r;
  logic [NOTE_W-1:0]       note_r;
  logic [VOICE_W-1:0]      idx_r;
  logic [VOICE_W-1:0]      victim_r;
  logic                    steal_r;
  logic [STAMP_BITS-1:0]   best_stamp_r;
  logic [NOTE_W-1:0]       best_note_r;
  logic [STAMP_BITS-1:0]   clock_r;
  logic [NOTES-1:0]        map_valid_r;
  logic [VOICES-1:0]       owner_valid_r;
  logic [VOICES-1:0]       stamp_valid_r;

  logic                    out_valid_r;
  logic [VOICE_W-1:0]      out_voice_r;
  logic                    out_voice_on_r;
  logic [PITCH_W-1:0]      out_pitch_r;
  logic                    out_last_r;

  logic                    accept;
  logic                    slot_free;
  logic                    last_idx;
  logic                    take_best;
  logic                    out_load;
  logic [NOTE_W-1:0]       rd_note;
  logic [STAMP_BITS-1:0]   rd_stamp;
  logic [STAMP_BITS-1:0]   clock_inc;
  logic [PITCH_W-1:0]      pitch_w;

  lva_pitch u_pitch (
    .note     (note_r),
    .pitch_hz (pitch_w)
  );

  // Shared decode of handshakes and scan data
  always_comb begin
    accept    = in_valid && !in_stall;
    slot_free = !out_valid_r || !out_stall;
    last_idx  = (idx_r == VOICE_W'(VOICES - 1));
    rd_note   = vce_rdata[VWORD_W-1 -: NOTE_W];
    rd_stamp  = stamp_valid_r[idx_r] ? vce_rdata[STAMP_BITS-1:0] : '0;
    take_best = (idx_r == '0) || (rd_stamp < best_stamp_r);
    clock_inc = clock_r + STAMP_BITS'(1);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_NOTE_ON:  state_nxt = map_valid_r[in_note] ? ST_LOOK : ST_SCAN;
            CMD_NOTE_OFF: state_nxt = map_valid_r[in_note] ? ST_LOOK : ST_IDLE;
            CMD_ALL_OFF:  state_nxt = ST_FLUSH;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOOK:  state_nxt = (cmd_r == CMD_NOTE_ON) ? ST_WRITE : ST_EMIT;
      ST_SCAN:  state_nxt = last_idx ? ST_WRITE : ST_SCAN;
      ST_WRITE: state_nxt = ST_EMIT;
      ST_EMIT:  state_nxt = slot_free ? ST_IDLE : ST_EMIT;
      ST_FLUSH: state_nxt = (slot_free && last_idx) ? ST_IDLE : ST_FLUSH;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Memory ports and handshake outputs
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    map_raddr = in_note;
    map_we    = (state_r == ST_WRITE);
    map_waddr = note_r;
    map_wdata = victim_r;
    vce_raddr = (state_r == ST_IDLE || last_idx) ? '0 : idx_r + VOICE_W'(1);
    vce_we    = (state_r == ST_WRITE);
    vce_waddr = victim_r;
    vce_wdata = {note_r, clock_inc};
    out_load  = (state_r == ST_EMIT || state_r == ST_FLUSH) && slot_free;
  end

  // Control state: FSM, valid bits, allocation clock, scan counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      map_valid_r   <= '0;
      owner_valid_r <= '0;
      stamp_valid_r <= '0;
      clock_r       <= '0;
      idx_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        idx_r <= '0;
        if (in_cmd == CMD_ALL_OFF) begin
          map_valid_r   <= '0;
          owner_valid_r <= '0;
        end
      end
      if (state_r == ST_SCAN || (state_r == ST_FLUSH && slot_free)) begin
        idx_r <= idx_r + VOICE_W'(1);
      end
      // Release a mapped note
      if (state_r == ST_LOOK && cmd_r == CMD_NOTE_OFF) begin
        map_valid_r[note_r]      <= 1'b0;
        owner_valid_r[map_rdata] <= 1'b0;
      end
      // Commit the allocation; drop the stolen voice's old note first
      if (state_r == ST_WRITE) begin
        if (steal_r && owner_valid_r[victim_r]) begin
          map_valid_r[best_note_r] <= 1'b0;
        end
        map_valid_r[note_r]     <= 1'b1;
        owner_valid_r[victim_r] <= 1'b1;
        stamp_valid_r[victim_r] <= 1'b1;
        clock_r                 <= clock_inc;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item payload and oldest-voice tracking
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= lva_cmd_t'(in_cmd);
      note_r <= in_note;
    end
    if (state_r == ST_LOOK) begin
      victim_r <= map_rdata;
      steal_r  <= 1'b0;
    end
    if (state_r == ST_SCAN) begin
      steal_r <= 1'b1;
      if (take_best) begin
        victim_r     <= idx_r;
        best_stamp_r <= rd_stamp;
        best_note_r  <= rd_note;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state_r == ST_FLUSH) begin
        out_voice_r    <= idx_r;
        out_voice_on_r <= 1'b0;
        out_pitch_r    <= '0;
        out_last_r     <= last_idx;
      end else begin
        out_voice_r    <= victim_r;
        out_voice_on_r <= (cmd_r == CMD_NOTE_ON);
        out_pitch_r    <= (cmd_r == CMD_NOTE_ON) ? pitch_w : '0;
        out_last_r     <= 1'b1;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_voice    = out_voice_r;
  assign out_voice_on = out_voice_on_r;
  assign out_pitch_hz = out_pitch_r;
  assign out_last     = out_last_r;

endmodule

// ----- hdl/lru_voice_allocator.sv -----
// Top level of the LRU voice allocator: memories and allocation sequencer.
//
// Input words carry cmd (note on, note off, all notes off) and a 7-bit note.
// Result words carry voice, voice_on, pitch_hz (14.16 Hz) and last.
// A word moves when valid is high and stall is low; in_stall is high while
// one input word is being worked on, so the block takes one word at a time.
// Steps from input accept to result valid:
//   note on, note unmapped : age scan reading each voice through the voice
//                            memory read port, then write-back and result load
//   note on, note mapped   : note map read, write-back, result load
//   note off               : note map read, result load; an unmapped note gives no result
//   all notes off          : 16 results, one per cycle while the receiver does not stall
// An unmapped note off or an unknown command is accepted and gives no result.
// The result register frees the input side: once a result is loaded the
// next word is accepted even while out_stall holds that result.
// A stalled receiver holds the result word stable and holds the sequencer before its next result load.
// Reset (rst_n low, synchronous) unmaps all notes and voices, zeroes all
// stamps and the allocation clock and drops any pending result.
module lru_voice_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [lva_pkg::CMD_W-1:0]   in_cmd,
  input  logic [lva_pkg::NOTE_W-1:0]  in_note,
  output logic                        in_stall,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lva_pkg::VOICE_W-1:0] out_voice,
  output logic                        out_voice_on,
  output logic [lva_pkg::PITCH_W-1:0] out_pitch_hz,
  output logic                        out_last
);
  import lva_pkg::*;

  logic               map_we;
  logic [NOTE_W-1:0]  map_waddr;
  logic [VOICE_W-1:0] map_wdata;
  logic [NOTE_W-1:0]  map_raddr;
  logic [VOICE_W-1:0] map_rdata;
  logic               vce_we;
  logic [VOICE_W-1:0] vce_waddr;
  logic [VWORD_W-1:0] vce_wdata;
  logic [VOICE_W-1:0] vce_raddr;
  logic [VWORD_W-1:0] vce_rdata;

  // Note to voice map
  lva_ram #(
    .WIDTH (VOICE_W),
    .DEPTH (NOTES)
  ) u_note_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // Per-voice owner note and allocation stamp
  lva_ram #(
    .WIDTH (VWORD_W),
    .DEPTH (VOICES)
  ) u_voice_mem (
    .clk   (clk),
    .we    (vce_we),
    .waddr (vce_waddr),
    .wdata (vce_wdata),
    .raddr (vce_raddr),
    .rdata (vce_rdata)
  );

  lva_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_cmd       (in_cmd),
    .in_note      (in_note),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_voice    (out_voice),
    .out_voice_on (out_voice_on),
    .out_pitch_hz (out_pitch_hz),
    .out_last     (out_last),
    .map_we       (map_we),
    .map_waddr    (map_waddr),
    .map_wdata    (map_wdata),
    .map_raddr    (map_raddr),
    .map_rdata    (map_rdata),
    .vce_we       (vce_we),
    .vce_waddr    (vce_waddr),
    .vce_wdata    (vce_wdata),
    .vce_raddr    (vce_raddr),
    .vce_rdata    (vce_rdata)
  );

endmodule

// ----- hdl/lva_checker.sv -----
// Port-level assertion checker for the voice allocator, bound to the top level.
`include "lru_voice_allocator_defines.svh"

module lva_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic [lva_pkg::CMD_W-1:0]   in_cmd,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [lva_pkg::VOICE_W-1:0] out_voice,
  input logic                        out_voice_on,
  input logic [lva_pkg::PITCH_W-1:0] out_pitch_hz,
  input logic                        out_last
);
  import lva_pkg::*;

  logic start_busy;
  logic stalled_word;

  assign start_busy   = in_valid && !in_stall &&
                        (in_cmd == CMD_NOTE_ON || in_cmd == CMD_ALL_OFF);
  assign stalled_word = out_valid && out_stall;

  // Reset drops any pending result word
  `LVA_ASSERT_RST(a_reset_clears_out, !rst_n, !out_valid)

  // Note on and all notes off always leave the block busy after acceptance
  `LVA_ASSERT_NEXT(a_busy_after_start, start_busy, in_stall)

  // A voice start is a single-word result with a real frequency
  `LVA_ASSERT_NOW(a_on_is_last, out_valid && out_voice_on,
                  out_last && out_pitch_hz != '0)

  // A stalled result word holds still
  `LVA_ASSERT_NEXT(a_out_hold, stalled_word,
                   out_valid && $stable(out_voice) && $stable(out_voice_on) &&
                   $stable(out_pitch_hz) && $stable(out_last))

  // A voice release carries no frequency
  `LVA_ASSERT_NOW(a_release_no_pitch, out_valid && !out_voice_on, out_pitch_hz == '0)

endmodule

bind lru_voice_allocator lva_checker u_lva_checker (.*);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the LRU voice allocator: directed and random MIDI words.
`timescale 1ns / 1ps

module tb_top;
  import lva_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_GAP = 20;

  // One voice event as it leaves the block.
  typedef struct packed {
    logic [VOICE_W-1:0] voice;
    logic               on;
    logic [PITCH_W-1:0] pitch;
    logic               last;
  } voice_evt_t;

  // Tracks note and voice ownership and holds the voice events still due.
  class voice_alloc_tracker;
    bit                  note_held[NOTES];
    bit [VOICE_W-1:0]    note_voice[NOTES];
    bit                  voice_busy[VOICES];
    bit [NOTE_W-1:0]     voice_note[VOICES];
    bit [STAMP_BITS-1:0] voice_age[VOICES];
    bit [STAMP_BITS-1:0] age_counter;
    voice_evt_t          due_events[$];
    int                  bad_events;

    function new();
      foreach (note_held[i]) begin
        note_held[i] = 1'b0;
        note_voice[i] = '0;
      end
      foreach (voice_busy[i]) begin
        voice_busy[i] = 1'b0;
        voice_note[i] = '0;
        voice_age[i] = '0;
      end
      age_counter = '0;
      bad_events = 0;
    endfunction

    // 2^(r/12) scaled by 2^24, rounded.
    function longint unsigned semitone_scale(int r);
      case (r)
        0:       return 64'd16777216;
        1:       return 64'd17774841;
        2:       return 64'd18831788;
        3:       return 64'd19951585;
        4:       return 64'd21137968;
        5:       return 64'd22394897;
        6:       return 64'd23726566;
        7:       return 64'd25137421;
        8:       return 64'd26632170;
        9:       return 64'd28215802;
        10:      return 64'd29893600;
        default: return 64'd31671166;
      endcase
    endfunction

    // Note frequency in 14.16 Hz, rounded half up.
    function logic [PITCH_W-1:0] tone_hz(logic [NOTE_W-1:0] note);
      int m;
      int shift;
      longint unsigned prod;
      m = int'(note) + 3;
      shift = 14 - m / 12;
      prod = 64'd440 * semitone_scale(m % 12);
      return PITCH_W'((prod + (64'd1 << (shift - 1))) >> shift);
    endfunction

    function void push_event(int voice, bit on, logic [PITCH_W-1:0] pitch, bit last);
      voice_evt_t e;
      e.voice = VOICE_W'(voice);
      e.on = on;
      e.pitch = pitch;
      e.last = last;
      due_events = {due_events, e};
    endfunction

    // Apply one accepted word; return the number of events it causes.
    function int note_word(logic [CMD_W-1:0] cmd, logic [NOTE_W-1:0] note);
      int v;
      case (cmd)
        CMD_NOTE_ON: begin
          if (note_held[note]) begin
            v = note_voice[note];
          end else begin
            // steal the oldest stamp, lowest index on a tie
            v = 0;
            for (int i = 1; i < VOICES; i++)
              if (voice_age[i] < voice_age[v]) v = i;
            if (voice_busy[v]) note_held[voice_note[v]] = 1'b0;
          end
          note_held[note] = 1'b1;
          note_voice[note] = VOICE_W'(v);
          voice_busy[v] = 1'b1;
          voice_note[v] = note;
          age_counter = age_counter + 1'b1;
          voice_age[v] = age_counter;
          push_event(v, 1'b1, tone_hz(note), 1'b1);
          return 1;
        end
        CMD_NOTE_OFF: begin
          if (!note_held[note]) return 0;
          v = note_voice[note];
          note_held[note] = 1'b0;
          if (voice_busy[v] && voice_note[v] == note) voice_busy[v] = 1'b0;
          push_event(v, 1'b0, '0, 1'b1);
          return 1;
        end
        CMD_ALL_OFF: begin
          for (int i = 0; i < VOICES; i++) begin
            push_event(i, 1'b0, '0, i == VOICES - 1);
            voice_busy[i] = 1'b0;
          end
          foreach (note_held[i]) note_held[i] = 1'b0;
          return VOICES;
        end
        default: return 0;
      endcase
    endfunction

    // Compare one delivered event with the oldest one due.
    function void check_event(voice_evt_t got);
      voice_evt_t want;
      if (due_events.size() == 0) begin
        $error("unexpected voice event: voice %0d on %0d pitch %0d last %0d",
               got.voice, got.on, got.pitch, got.last);
        bad_events++;
        return;
      end
      want = due_events.pop_front();
      if (got.voice !== want.voice) begin
        $error("voice: expected %0d, got %0d", want.voice, got.voice);
        bad_events++;
      end
      if (got.on !== want.on) begin
        $error("voice_on: expected %0d, got %0d", want.on, got.on);
        bad_events++;
      end
      if (got.pitch !== want.pitch) begin
        $error("pitch_hz: expected %0d, got %0d", want.pitch, got.pitch);
        bad_events++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        bad_events++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic [CMD_W-1:0]   in_cmd;
  logic [NOTE_W-1:0]  in_note;
  logic               in_stall;
  logic               out_valid;
  logic               out_stall;
  logic [VOICE_W-1:0] out_voice;
  logic               out_voice_on;
  logic [PITCH_W-1:0] out_pitch_hz;
  logic               out_last;

  voice_alloc_tracker tracker;
  int tx_idle_pct;
  int rx_idle_pct;
  int cycles;

  lru_voice_allocator DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_cmd       (in_cmd),
    .in_note      (in_note),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_voice    (out_voice),
    .out_voice_on (out_voice_on),
    .out_pitch_hz (out_pitch_hz),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Check delivered words, then pick the next stall value.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      tracker.check_event({out_voice, out_voice_on, out_pitch_hz, out_last});
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // Send one word, hold it until accepted, then predict its events.
  task automatic drive_word(input logic [CMD_W-1:0] cmd, input logic [NOTE_W-1:0] note,
                            output int n_events);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_note <= note;
    do @(posedge clk); while (in_stall !== 1'b0);
    n_events = tracker.note_word(cmd, note);
  endtask

  // Random words: mostly on and off, half of them over a small note pool, some noise.
  task automatic run_phase(input int tx_pct, input int rx_pct, input int count);
    int live;
    int pick;
    int n;
    logic [CMD_W-1:0]  cmd;
    logic [NOTE_W-1:0] note;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    live = 0;
    while (live < count) begin
      pick = $urandom_range(99);
      if ($urandom_range(1) == 0) note = NOTE_W'($urandom_range(127));
      else note = NOTE_W'(48 + $urandom_range(23));
      if (pick < 52) cmd = CMD_NOTE_ON;
      else if (pick < 88) cmd = CMD_NOTE_OFF;
      else if (pick < 93) cmd = CMD_ALL_OFF;
      else cmd = CMD_UNUSED;
      drive_word(cmd, note, n);
      live++;
    end
  endtask

  initial begin
    int n;
    tracker = new();
    cycles <= 0;
    tx_idle_pct = 37;
    rx_idle_pct = 64;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_cmd <= CMD_NOTE_ON;
    in_note <= '0;
    out_stall <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: first voice on tie, reuse, range ends, mapped and unmapped off, unknown command, all notes off
    drive_word(CMD_NOTE_ON, 7'd69, n);
    drive_word(CMD_NOTE_ON, 7'd69, n);
    drive_word(CMD_NOTE_ON, 7'd0, n);
    drive_word(CMD_NOTE_ON, 7'd127, n);
    drive_word(CMD_NOTE_OFF, 7'd127, n);
    drive_word(CMD_NOTE_OFF, 7'd127, n);
    drive_word(CMD_UNUSED, 7'd127, n);
    drive_word(CMD_ALL_OFF, 7'd85, n);
    // fill every voice, then steal the oldest
    for (int i = 0; i < VOICES + 1; i++)
      drive_word(CMD_NOTE_ON, NOTE_W'(10 + i), n);

    run_phase(37, 64, 45);
    run_phase(64, 37, 45);
    run_phase(0, 0, 45);
    in_valid <= 1'b0;

    // Drain outstanding events, then watch for strays.
    while (tracker.due_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.bad_events == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
